// File: src/trj_pkg.sv
// Shared types, constants and tables of the trajectory point generator.
`timescale 1ns / 1ps

package trj_pkg;

  // Fixed-point widths inside the datapath
  localparam int unsigned VEC_W   = 32;  // vectoring x/y
  localparam int unsigned SC_W    = 34;  // rotation x/y, Q2.30 with headroom
  localparam int unsigned SCZ_W   = 33;  // rotation residual angle
  localparam int unsigned RAD_W   = 20;  // handle radius, signed integer (Q20.0)
  localparam int unsigned RXY_W   = 24;  // radius after aspect
  localparam int unsigned AMP_W   = 25;  // amplitude before the final multiply
  localparam int unsigned TRG_W   = 35;  // trig factor, Q2.30
  localparam int unsigned TERM_W  = 30;  // offset from the centre node
  localparam int unsigned LINE_W  = 19;  // line offset

  localparam int unsigned DIV_STAGES = 8;
  localparam int unsigned DIV_BITS   = 4;

  localparam logic [16:0] INV_GAIN_Q16 = 17'd39797;
  localparam logic [29:0] INV_GAIN_Q30 = 30'd652032874;
  localparam logic [7:0]  MAX_SIDES    = 8'd255;
  localparam logic [7:0]  MIN_SIDES    = 8'd3;

  localparam logic [2:0] SHAPE_LINE     = 3'd0;
  localparam logic [2:0] SHAPE_CIRCLE   = 3'd1;
  localparam logic [2:0] SHAPE_SPIRAL   = 3'd2;
  localparam logic [2:0] SHAPE_LISSA    = 3'd3;
  localparam logic [2:0] SHAPE_ROSE     = 3'd4;
  localparam logic [2:0] SHAPE_POLYGON  = 3'd5;

  localparam logic [1:0] OMODE_XY  = 2'd0;
  localparam logic [1:0] OMODE_XYZ = 2'd1;

  typedef enum logic [2:0] {
    CFG_MODE   = 3'd0,
    CFG_SPEED  = 3'd1,
    CFG_HEIGHT = 3'd2,
    CFG_ASP_X  = 3'd3,
    CFG_ASP_Y  = 3'd4,
    CFG_PHASE  = 3'd5,
    CFG_FREQ_X = 3'd6,
    CFG_FREQ_Y = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [16:0]        tick_position;
    logic signed [15:0] centre_x;
    logic signed [15:0] centre_y;
    logic signed [15:0] handle_x;
    logic signed [15:0] handle_y;
    logic               has_handle;
    logic               has_nodes;
    logic               last_source;
  } in_t;

  typedef struct packed {
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
    logic signed [15:0] point_z;
    logic               point_valid;
    logic               is_spatial;
    logic               end_of_tick;
  } out_t;

  // Per-item values that ride along the pipeline
  typedef struct packed {
    logic                      nodes;
    logic                      last;
    logic signed [15:0]        ax;
    logic signed [15:0]        ay;
    logic signed [16:0]        dx;
    logic signed [16:0]        dy;
    logic [16:0]               pos;
    logic [16:0]               u;
    logic                      zero;
    logic signed [RAD_W-1:0]   r;
    logic [31:0]               phi;
    logic [32:0]               th;
    logic [32:0]               fxu;
    logic [7:0]                k;
    logic [16:0]               f;
    logic signed [LINE_W-1:0]  lnx;
    logic signed [LINE_W-1:0]  lny;
    logic signed [RXY_W-1:0]   rx;
    logic signed [RXY_W-1:0]   ry;
    logic [31:0]               rose_a;
  } car_t;

  // atan(2^-i) in 32-bit turns
  function automatic logic [31:0] atan_turn(input logic [4:0] idx);
    logic [31:0] v;
    unique case (idx)
      5'd0:    v = 32'h20000000;
      5'd1:    v = 32'h12E4051E;
      5'd2:    v = 32'h09FB385B;
      5'd3:    v = 32'h051111D4;
      5'd4:    v = 32'h028B0D43;
      5'd5:    v = 32'h0145D7E1;
      5'd6:    v = 32'h00A2F61E;
      5'd7:    v = 32'h00517C55;
      5'd8:    v = 32'h0028BE53;
      5'd9:    v = 32'h00145F2F;
      5'd10:   v = 32'h000A2F98;
      5'd11:   v = 32'h000517CC;
      5'd12:   v = 32'h00028BE6;
      5'd13:   v = 32'h000145F3;
      5'd14:   v = 32'h0000A2FA;
      5'd15:   v = 32'h0000517D;
      5'd16:   v = 32'h000028BE;
      5'd17:   v = 32'h0000145F;
      5'd18:   v = 32'h00000A30;
      5'd19:   v = 32'h00000518;
      5'd20:   v = 32'h0000028C;
      5'd21:   v = 32'h00000146;
      5'd22:   v = 32'h000000A3;
      5'd23:   v = 32'h00000051;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [31:0] v);
    logic signed [15:0] o;
    if (v > 32'sd32767) begin
      o = 16'sh7FFF;
    end else if (v < -32'sd32768) begin
      o = 16'sh8000;
    end else begin
      o = v[15:0];
    end
    return o;
  endfunction

endpackage

// File: src/trajectory_point_generator_top.sv
// Top level: fully pipelined trajectory point datapath with CORDIC units.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+-----------------------------
//  input    | start / busy              | item_i   (in_t)
//  result   | result_valid_o (strobe)   | result_o (out_t)
//  config   | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// One item enters per cycle; busy stays low. A result passes through
// the vectoring CORDIC, the eight-stage polygon divider and the
// sine/cosine CORDIC in series.
// Reset clears the valid bits and loads the register defaults.
// Results are strobed for one cycle; the receiver cannot stall them.
`timescale 1ns / 1ps

module trajectory_point_generator_top
  import trj_pkg::*;
#(
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  in_t         item_i,
  output logic        result_valid_o,
  output out_t        result_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  localparam int unsigned NS     = CORDIC_STAGES;
  localparam int unsigned M1_IX  = NS + 2;
  localparam int unsigned M2_IX  = NS + 3;
  localparam int unsigned SEL_IX = NS + 4 + DIV_STAGES;
  localparam int unsigned P1_IX  = 2 * NS + 5 + DIV_STAGES;
  localparam int unsigned P2_IX  = P1_IX + 1;
  localparam int unsigned DEPTH  = P2_IX + 1;

  // ---------------- configuration ----------------
  logic [5:0]  mode_q;
  logic [15:0] speed_q, phase_q, frx_q, fry_q;
  logic signed [15:0] height_q, aspx_q, aspy_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= 6'd0;
      speed_q  <= 16'd256;
      height_q <= 16'sd0;
      aspx_q   <= 16'sd4096;
      aspy_q   <= 16'sd4096;
      phase_q  <= 16'd0;
      frx_q    <= 16'd256;
      fry_q    <= 16'd256;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_MODE:   mode_q   <= cfg_data_i[5:0];
        CFG_SPEED:  speed_q  <= cfg_data_i;
        CFG_HEIGHT: height_q <= cfg_data_i;
        CFG_ASP_X:  aspx_q   <= cfg_data_i;
        CFG_ASP_Y:  aspy_q   <= cfg_data_i;
        CFG_PHASE:  phase_q  <= cfg_data_i;
        CFG_FREQ_X: frx_q    <= cfg_data_i;
        CFG_FREQ_Y: fry_q    <= cfg_data_i;
      endcase
    end
  end

  logic [2:0] shape;
  logic [1:0] omode;
  logic [7:0] n_sides;

  assign shape = mode_q[2:0];
  assign omode = mode_q[5:4];

  always_comb begin
    if (frx_q[15:8] > MAX_SIDES) begin
      n_sides = MAX_SIDES;
    end else if (frx_q[15:8] < MIN_SIDES) begin
      n_sides = MIN_SIDES;
    end else begin
      n_sides = frx_q[15:8];
    end
  end

  // ---------------- pipeline valid bits ----------------
  logic [DEPTH-1:0] vld_q;
  logic             res_vld_q;

  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      res_vld_q <= 1'b0;
    end else begin
      vld_q     <= {vld_q[DEPTH-2:0], start};
      res_vld_q <= vld_q[DEPTH-1];
    end
  end

  car_t car_q [DEPTH];

  // ---------------- stage 0: speed scaling, node offset ----------------
  car_t               s0_d;
  logic [32:0]        raw;
  logic signed [15:0] bx, by;

  always_comb begin
    s0_d       = '0;
    raw        = item_i.tick_position * speed_q;
    bx         = item_i.has_handle ? item_i.handle_x : item_i.centre_x;
    by         = item_i.has_handle ? item_i.handle_y : item_i.centre_y;
    s0_d.nodes = item_i.has_nodes;
    s0_d.last  = item_i.last_source;
    s0_d.ax    = item_i.centre_x;
    s0_d.ay    = item_i.centre_y;
    s0_d.dx    = 17'(bx) - 17'(item_i.centre_x);
    s0_d.dy    = 17'(by) - 17'(item_i.centre_y);
    s0_d.pos   = raw[24:8];
  end

  always_ff @(posedge clk_i) begin
    car_q[0] <= s0_d;
  end

  // ---------------- stage 1: fraction, vectoring setup ----------------
  logic signed [VEC_W-1:0] vx_q [NS+1];
  logic signed [VEC_W-1:0] vy_q [NS+1];
  logic [31:0]             vz_q [NS+1];

  car_t                    s1_d;
  logic signed [VEC_W-1:0] x0, y0;

  always_comb begin
    s1_d = car_q[0];
    // walk backwards on odd laps in ping-pong mode
    if (mode_q[3] && car_q[0].pos[16]) begin
      s1_d.u = 17'(17'h10000 - {1'b0, car_q[0].pos[15:0]});
    end else begin
      s1_d.u = {1'b0, car_q[0].pos[15:0]};
    end
    s1_d.zero = (car_q[0].dx == 17'sd0) && (car_q[0].dy == 17'sd0);
    x0 = VEC_W'(car_q[0].dx) <<< 12;
    y0 = VEC_W'(car_q[0].dy) <<< 12;
  end

  always_ff @(posedge clk_i) begin
    car_q[1] <= s1_d;
    if (x0 < 0) begin
      vx_q[0] <= -x0;
      vy_q[0] <= -y0;
      vz_q[0] <= 32'h80000000;
    end else begin
      vx_q[0] <= x0;
      vy_q[0] <= y0;
      vz_q[0] <= 32'h0;
    end
  end

  // ---------------- vectoring CORDIC ----------------
  for (genvar i = 0; i < NS; i++) begin : g_vec
    logic signed [VEC_W-1:0] xs, ys;
    logic [31:0]             at;

    assign xs = vx_q[i] >>> i;
    assign ys = vy_q[i] >>> i;
    assign at = atan_turn(5'(i));

    always_ff @(posedge clk_i) begin
      if (!vy_q[i][VEC_W-1]) begin
        vx_q[i+1] <= vx_q[i] + ys;
        vy_q[i+1] <= vy_q[i] - xs;
        vz_q[i+1] <= vz_q[i] + at;
      end else begin
        vx_q[i+1] <= vx_q[i] - ys;
        vy_q[i+1] <= vy_q[i] + xs;
        vz_q[i+1] <= vz_q[i] - at;
      end
      car_q[2+i] <= car_q[1+i];
    end
  end

  // ---------------- M1: radius, angle, frequency products ----------------
  car_t               m1_d;
  logic signed [49:0] mag_p;
  logic [24:0]        sp;
  logic [7:0]         nm1;
  logic signed [34:0] lpx, lpy;

  always_comb begin
    m1_d     = car_q[M1_IX-1];
    mag_p    = vx_q[NS] * $signed({1'b0, INV_GAIN_Q16});
    m1_d.r   = m1_d.zero ? '0 : $signed(mag_p[RAD_W+27:28]);
    m1_d.phi = (m1_d.zero ? 32'h0 : vz_q[NS]) + {phase_q, 16'h0};
    m1_d.th  = fry_q * m1_d.u;
    m1_d.fxu = frx_q * m1_d.u;
    sp       = m1_d.u * n_sides;
    nm1      = n_sides - 8'd1;
    // clamp the side index at the closing corner
    m1_d.k   = (sp[24:16] > {1'b0, nm1}) ? nm1 : sp[23:16];
    m1_d.f   = sp[16:0] - {m1_d.k[0], 16'h0};
    lpx      = m1_d.dx * $signed({1'b0, m1_d.u});
    lpy      = m1_d.dy * $signed({1'b0, m1_d.u});
    m1_d.lnx = $signed(lpx[LINE_W+15:16]);
    m1_d.lny = $signed(lpy[LINE_W+15:16]);
  end

  always_ff @(posedge clk_i) begin
    car_q[M1_IX] <= m1_d;
  end

  // ---------------- M2: aspect, rose angle, divider setup ----------------
  logic [7:0]  dra_q [DIV_STAGES+1];
  logic [7:0]  drb_q [DIV_STAGES+1];
  logic [31:0] dqa_q [DIV_STAGES+1];
  logic [31:0] dqb_q [DIV_STAGES+1];

  car_t               m2_d;
  logic signed [35:0] rxp, ryp;
  logic [47:0]        rose_p;
  logic [8:0]         kb;

  always_comb begin
    m2_d        = car_q[M2_IX-1];
    rxp         = m2_d.r * aspx_q;
    ryp         = m2_d.r * aspy_q;
    m2_d.rx     = $signed(rxp[RXY_W+11:12]);
    m2_d.ry     = $signed(ryp[RXY_W+11:12]);
    rose_p      = frx_q * m2_d.th[31:0];
    m2_d.rose_a = rose_p[31:0];
    kb          = {1'b0, m2_d.k} + 9'd1;
  end

  always_ff @(posedge clk_i) begin
    car_q[M2_IX] <= m2_d;
    dra_q[0]     <= m2_d.k;
    // a full turn wraps to zero
    drb_q[0]     <= (kb >= {1'b0, n_sides}) ? 8'd0 : kb[7:0];
    dqa_q[0]     <= 32'h0;
    dqb_q[0]     <= 32'h0;
  end

  // ---------------- corner angle divider: k * 2^32 / n ----------------
  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
    logic [7:0]  ra_d, rb_d;
    logic [31:0] qa_d, qb_d;
    logic [8:0]  ta, tb;

    always_comb begin
      ra_d = dra_q[j];
      rb_d = drb_q[j];
      qa_d = dqa_q[j];
      qb_d = dqb_q[j];
      ta   = '0;
      tb   = '0;
      for (int b = 0; b < DIV_BITS; b++) begin
        ta = {ra_d, 1'b0};
        tb = {rb_d, 1'b0};
        if (ta >= {1'b0, n_sides}) begin
          ra_d = 8'(ta - {1'b0, n_sides});
          qa_d = {qa_d[30:0], 1'b1};
        end else begin
          ra_d = ta[7:0];
          qa_d = {qa_d[30:0], 1'b0};
        end
        if (tb >= {1'b0, n_sides}) begin
          rb_d = 8'(tb - {1'b0, n_sides});
          qb_d = {qb_d[30:0], 1'b1};
        end else begin
          rb_d = tb[7:0];
          qb_d = {qb_d[30:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      dra_q[j+1]       <= ra_d;
      drb_q[j+1]       <= rb_d;
      dqa_q[j+1]       <= qa_d;
      dqb_q[j+1]       <= qb_d;
      car_q[M2_IX+1+j] <= car_q[M2_IX+j];
    end
  end

  // ---------------- SEL: rotation angles and half-turn fold ----------------
  logic signed [SC_W-1:0]  sx_q [2][NS+1];
  logic signed [SC_W-1:0]  sy_q [2][NS+1];
  logic signed [SCZ_W-1:0] sz_q [2][NS+1];
  logic                    sn_q [2][NS+1];

  car_t        sel_c;
  logic [31:0] ang [2];
  logic [31:0] fold [2];
  logic        neg [2];

  always_comb begin
    sel_c = car_q[SEL_IX-1];
    ang[0] = 32'h0;
    ang[1] = 32'h0;
    unique case (shape)
      SHAPE_CIRCLE: begin
        ang[0] = sel_c.phi - {sel_c.u[15:0], 16'h0};
      end
      SHAPE_SPIRAL: begin
        ang[0] = sel_c.phi + {sel_c.u[14:0], 17'h0};
      end
      SHAPE_LISSA: begin
        ang[0] = sel_c.phi + {sel_c.fxu[23:0], 8'h0};
        ang[1] = {sel_c.th[23:0], 8'h0};
      end
      SHAPE_ROSE: begin
        ang[0] = sel_c.rose_a;
        ang[1] = {sel_c.th[23:0], 8'h0} + sel_c.phi;
      end
      SHAPE_POLYGON: begin
        ang[0] = dqa_q[DIV_STAGES] + sel_c.phi;
        ang[1] = dqb_q[DIV_STAGES] + sel_c.phi;
      end
      default: begin
        ang[0] = 32'h0;
        ang[1] = 32'h0;
      end
    endcase
    for (int l = 0; l < 2; l++) begin
      neg[l]  = 1'(((ang[l] + 32'h40000000) >> 31));
      fold[l] = neg[l] ? (ang[l] ^ 32'h80000000) : ang[l];
    end
  end

  always_ff @(posedge clk_i) begin
    car_q[SEL_IX] <= sel_c;
  end

  for (genvar l = 0; l < 2; l++) begin : g_seed
    always_ff @(posedge clk_i) begin
      sx_q[l][0] <= $signed({{(SC_W-30){1'b0}}, INV_GAIN_Q30});
      sy_q[l][0] <= '0;
      sz_q[l][0] <= $signed({fold[l][31], fold[l]});
      sn_q[l][0] <= neg[l];
    end
  end

  // ---------------- rotation CORDIC, two lanes ----------------
  for (genvar i = 0; i < NS; i++) begin : g_rot
    logic [SCZ_W-1:0] at;

    assign at = {1'b0, atan_turn(5'(i))};

    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic signed [SC_W-1:0] xs, ys;

      assign xs = sx_q[l][i] >>> i;
      assign ys = sy_q[l][i] >>> i;

      always_ff @(posedge clk_i) begin
        if (!sz_q[l][i][SCZ_W-1]) begin
          sx_q[l][i+1] <= sx_q[l][i] - ys;
          sy_q[l][i+1] <= sy_q[l][i] + xs;
          sz_q[l][i+1] <= sz_q[l][i] - $signed(at);
        end else begin
          sx_q[l][i+1] <= sx_q[l][i] + ys;
          sy_q[l][i+1] <= sy_q[l][i] - xs;
          sz_q[l][i+1] <= sz_q[l][i] + $signed(at);
        end
        sn_q[l][i+1] <= sn_q[l][i];
      end
    end

    always_ff @(posedge clk_i) begin
      car_q[SEL_IX+1+i] <= car_q[SEL_IX+i];
    end
  end

  // ---------------- P1: amplitude and trig factor per shape ----------------
  logic signed [AMP_W-1:0] ampx_q, ampy_q;
  logic signed [TRG_W-1:0] trgx_q, trgy_q;

  car_t                    p1_c;
  logic signed [SC_W-1:0]  ca, sa, cb, sb;
  logic signed [SC_W:0]    dcx, dcy;
  logic signed [52:0]      pcx, pcy;
  logic signed [57:0]      rrx, rry;
  logic signed [41:0]      spx, spy;
  logic signed [AMP_W-1:0] ampx_d, ampy_d;
  logic signed [TRG_W-1:0] trgx_d, trgy_d;

  always_comb begin
    p1_c = car_q[P1_IX-1];
    ca   = sn_q[0][NS] ? -sx_q[0][NS] : sx_q[0][NS];
    sa   = sn_q[0][NS] ? -sy_q[0][NS] : sy_q[0][NS];
    cb   = sn_q[1][NS] ? -sx_q[1][NS] : sx_q[1][NS];
    sb   = sn_q[1][NS] ? -sy_q[1][NS] : sy_q[1][NS];
    dcx  = (SC_W+1)'(cb) - (SC_W+1)'(ca);
    dcy  = (SC_W+1)'(sb) - (SC_W+1)'(sa);
    pcx  = dcx * $signed({1'b0, p1_c.f});
    pcy  = dcy * $signed({1'b0, p1_c.f});
    rrx  = p1_c.rx * ca;
    rry  = p1_c.ry * ca;
    spx  = p1_c.rx * $signed({1'b0, p1_c.u});
    spy  = p1_c.ry * $signed({1'b0, p1_c.u});
    ampx_d = AMP_W'(p1_c.rx);
    ampy_d = AMP_W'(p1_c.ry);
    trgx_d = TRG_W'(ca);
    trgy_d = TRG_W'(sa);
    unique case (shape)
      SHAPE_SPIRAL: begin
        ampx_d = $signed(spx[AMP_W+15:16]);
        ampy_d = $signed(spy[AMP_W+15:16]);
      end
      SHAPE_LISSA: begin
        trgx_d = TRG_W'(sa);
        trgy_d = TRG_W'(sb);
      end
      SHAPE_ROSE: begin
        ampx_d = $signed(rrx[AMP_W+29:30]);
        ampy_d = $signed(rry[AMP_W+29:30]);
        trgx_d = TRG_W'(cb);
        trgy_d = TRG_W'(sb);
      end
      SHAPE_POLYGON: begin
        // interpolate between the two corners
        trgx_d = TRG_W'(TRG_W'(ca) + TRG_W'($signed(pcx[52:16])));
        trgy_d = TRG_W'(TRG_W'(sa) + TRG_W'($signed(pcy[52:16])));
      end
      default: begin
        ampx_d = AMP_W'(p1_c.rx);
        ampy_d = AMP_W'(p1_c.ry);
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    car_q[P1_IX] <= p1_c;
    ampx_q       <= ampx_d;
    ampy_q       <= ampy_d;
    trgx_q       <= trgx_d;
    trgy_q       <= trgy_d;
  end

  // ---------------- P2: offset = amplitude * trig ----------------
  logic signed [TERM_W-1:0] tx_q, ty_q;
  logic signed [59:0]       txp, typ;

  assign txp = ampx_q * trgx_q;
  assign typ = ampy_q * trgy_q;

  always_ff @(posedge clk_i) begin
    car_q[P2_IX] <= car_q[P1_IX];
    tx_q         <= $signed(txp[TERM_W+29:30]);
    ty_q         <= $signed(typ[TERM_W+29:30]);
  end

  // ---------------- result register ----------------
  car_t               oc;
  out_t               res_d, res_q;
  logic signed [31:0] px, py;

  always_comb begin
    oc = car_q[P2_IX];
    unique case (shape)
      SHAPE_LINE: begin
        px = 32'(oc.ax) + 32'(oc.lnx);
        py = 32'(oc.ay) + 32'(oc.lny);
      end
      SHAPE_CIRCLE, SHAPE_SPIRAL, SHAPE_LISSA, SHAPE_ROSE, SHAPE_POLYGON: begin
        px = 32'(oc.ax) + 32'(tx_q);
        py = 32'(oc.ay) + 32'(ty_q);
      end
      default: begin
        px = 32'(oc.ax);
        py = 32'(oc.ay);
      end
    endcase
    res_d.is_spatial  = (omode != OMODE_XY);
    res_d.end_of_tick = oc.last;
    // drop the point for a source without nodes
    if (oc.nodes) begin
      res_d.point_x     = sat16(px);
      res_d.point_y     = sat16(py);
      res_d.point_z     = (omode == OMODE_XYZ) ? height_q : 16'sd0;
      res_d.point_valid = 1'b1;
    end else begin
      res_d.point_x     = 16'sd0;
      res_d.point_y     = 16'sd0;
      res_d.point_z     = 16'sd0;
      res_d.point_valid = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign result_o       = res_q;
  assign result_valid_o = res_vld_q;

endmodule

// File: verif/trajectory_point_generator_top_tb.sv
// Self-checking testbench of the trajectory point generator.
`timescale 1ns / 1ps

module trajectory_point_generator_top_tb
  import trj_pkg::*;
();

  localparam int STAGES  = 16;
  localparam int LATENCY = 2 * STAGES + 16;
  localparam int WD_LIMIT = 20000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  in_t         item_i = '0;
  logic        result_valid_o;
  out_t        result_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;

  trajectory_point_generator_top #(.CORDIC_STAGES(STAGES)) u_top (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Predictor register copy
  logic [5:0]  p_mode = '0;
  logic [15:0] p_speed = 16'd256, p_height = '0, p_phase = '0;
  logic [15:0] p_asx = 16'd4096, p_asy = 16'd4096, p_fx = 16'd256, p_fy = 16'd256;

  in_t  pending_items[$];
  out_t expected_points[$];
  int   send_idle_pct = 0;
  int   fail_count = 0;
  int   idle_cycles = 0;
  bit   hold_off = 1'b0;

  localparam logic [31:0] ATAN_TBL [24] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051};

  function automatic longint fl_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic logic [15:0] clamp16(longint v);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  task automatic polar_of(input longint dx, input longint dy,
                          output longint mag, output logic [31:0] ang);
    longint x, y, xs, ys;
    x = dx * 4096;
    y = dy * 4096;
    ang = '0;
    if (dx == 0 && dy == 0) begin
      mag = 0;
      return;
    end
    if (x < 0) begin
      x = -x; y = -y; ang = 32'h80000000;
    end
    for (int i = 0; i < STAGES; i++) begin
      xs = fl_shr(x, i); ys = fl_shr(y, i);
      if (y >= 0) begin
        x += ys; y -= xs; ang += ATAN_TBL[i];
      end else begin
        x -= ys; y += xs; ang -= ATAN_TBL[i];
      end
    end
    mag = fl_shr(x * 39797, 28);
  endtask

  task automatic cos_sin(input logic [31:0] angle, output longint c, output longint s);
    bit neg;
    longint x, y, z, xs, ys;
    logic [31:0] t;
    t = angle + 32'h40000000;
    neg = t[31];
    if (neg) angle -= 32'h80000000;
    x = 652032874; y = 0;
    z = longint'($signed(angle));
    for (int i = 0; i < STAGES; i++) begin
      xs = fl_shr(x, i); ys = fl_shr(y, i);
      if (z >= 0) begin
        x -= ys; y += xs; z -= ATAN_TBL[i];
      end else begin
        x += ys; y -= xs; z += ATAN_TBL[i];
      end
    end
    c = neg ? -x : x;
    s = neg ? -y : y;
  endtask

  function automatic longint mul30(longint v, longint q);
    return fl_shr(v * q, 30);
  endfunction

  task automatic predict_point(input in_t it, output out_t res);
    logic [32:0] raw;
    longint u, ax, ay, bx, by, dx, dy, r, rx, ry, px, py, c, s, c2, s2;
    longint n, sp, k, f;
    logic [31:0] phi;
    logic [63:0] th, q0, q1;
    logic [1:0] om;
    raw = 33'(it.tick_position) * 33'(p_speed);
    om = p_mode[5:4];
    u = (p_mode[3] && raw[24]) ? 65536 - longint'(raw[23:8]) : longint'(raw[23:8]);
    res = '0;
    res.point_z = (om == OMODE_XYZ) ? p_height : 16'd0;
    res.is_spatial = (om != OMODE_XY);
    res.end_of_tick = it.last_source;
    if (!it.has_nodes) begin
      res.point_z = '0;
      return;
    end
    res.point_valid = 1'b1;
    ax = it.centre_x; ay = it.centre_y;
    bx = it.has_handle ? longint'(it.handle_x) : ax;
    by = it.has_handle ? longint'(it.handle_y) : ay;
    dx = bx - ax; dy = by - ay;
    polar_of(dx, dy, r, phi);
    phi += {p_phase, 16'd0};
    rx = fl_shr(r * longint'($signed(p_asx)), 12);
    ry = fl_shr(r * longint'($signed(p_asy)), 12);
    px = ax; py = ay;
    case (p_mode[2:0])
      SHAPE_LINE: begin
        px = ax + fl_shr(dx * u, 16);
        py = ay + fl_shr(dy * u, 16);
      end
      SHAPE_CIRCLE: begin
        th = 64'(u) << 16;
        cos_sin(phi - th[31:0], c, s);
        px = ax + mul30(rx, c); py = ay + mul30(ry, s);
      end
      SHAPE_SPIRAL: begin
        th = 64'(u) << 17;
        cos_sin(phi + th[31:0], c, s);
        px = ax + mul30(fl_shr(rx * u, 16), c);
        py = ay + mul30(fl_shr(ry * u, 16), s);
      end
      SHAPE_LISSA: begin
        th = (64'(p_fx) * 64'(u)) << 8;
        cos_sin(phi + th[31:0], c, s);
        th = (64'(p_fy) * 64'(u)) << 8;
        cos_sin(th[31:0], c2, s2);
        px = ax + mul30(rx, s); py = ay + mul30(ry, s2);
      end
      SHAPE_ROSE: begin
        th = 64'(p_fy) * 64'(u);
        q0 = 64'(p_fx) * th;
        cos_sin(q0[31:0], c2, s2);
        q1 = th << 8;
        cos_sin(q1[31:0] + phi, c, s);
        px = ax + mul30(mul30(rx, c2), c);
        py = ay + mul30(mul30(ry, c2), s);
      end
      SHAPE_POLYGON: begin
        n = p_fx[15:8];
        if (n > 255) n = 255;
        if (n < 3) n = 3;
        sp = u * n;
        k = sp >>> 16;
        if (k > n - 1) k = n - 1;
        f = sp - k * 65536;
        q0 = (64'(k) << 32) / 64'(n);
        q1 = (64'(k + 1) << 32) / 64'(n);
        cos_sin(q0[31:0] + phi, c, s);
        cos_sin(q1[31:0] + phi, c2, s2);
        px = ax + mul30(rx, c + fl_shr((c2 - c) * f, 16));
        py = ay + mul30(ry, s + fl_shr((s2 - s) * f, 16));
      end
      default: ;
    endcase
    res.point_x = clamp16(px);
    res.point_y = clamp16(py);
  endtask

  // Driver
  always @(posedge clk_i) begin
    out_t exp_res;
    if (rst_ni) begin
      if (start && !busy) begin
        predict_point(item_i, exp_res);
        expected_points.push_back(exp_res);
        void'(pending_items.pop_front());
      end
      if (pending_items.size() > 0 && !hold_off &&
          $urandom_range(99) >= send_idle_pct) begin
        start  <= 1'b1;
        item_i <= (start && !busy) ? pending_items[0] : pending_items[0];
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor
  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && result_valid_o) begin
      if (expected_points.size() == 0) begin
        $error("unexpected result %h", result_o);
        fail_count++;
      end else begin
        want = expected_points.pop_front();
        if (result_o.point_x !== want.point_x) begin
          $error("point_x exp %0d got %0d", want.point_x, result_o.point_x); fail_count++;
        end
        if (result_o.point_y !== want.point_y) begin
          $error("point_y exp %0d got %0d", want.point_y, result_o.point_y); fail_count++;
        end
        if (result_o.point_z !== want.point_z) begin
          $error("point_z exp %0d got %0d", want.point_z, result_o.point_z); fail_count++;
        end
        if (result_o.point_valid !== want.point_valid) begin
          $error("point_valid exp %0b got %0b", want.point_valid, result_o.point_valid);
          fail_count++;
        end
        if (result_o.is_spatial !== want.is_spatial) begin
          $error("is_spatial exp %0b got %0b", want.is_spatial, result_o.is_spatial);
          fail_count++;
        end
        if (result_o.end_of_tick !== want.end_of_tick) begin
          $error("end_of_tick exp %0b got %0b", want.end_of_tick, result_o.end_of_tick);
          fail_count++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    if ((start && !busy) || result_valid_o || (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WD_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic write_reg(input cfg_idx_e idx, input logic [15:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_MODE:   p_mode = val[5:0];
      CFG_SPEED:  p_speed = val;
      CFG_HEIGHT: p_height = val;
      CFG_ASP_X:  p_asx = val;
      CFG_ASP_Y:  p_asy = val;
      CFG_PHASE:  p_phase = val;
      CFG_FREQ_X: p_fx = val;
      default:    p_fy = val;
    endcase
  endtask

  task automatic drain_all();
    while (pending_items.size() > 0 || expected_points.size() > 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  function automatic in_t rand_item();
    in_t it;
    it = in_t'({$urandom, $urandom, $urandom});
    it.tick_position = ($urandom_range(49) == 0) ? 17'd65536 : 17'($urandom_range(65535));
    if ($urandom_range(3) == 0) begin
      it.centre_x = 16'($signed($urandom_range(8191)) - 4096);
      it.centre_y = 16'($signed($urandom_range(8191)) - 4096);
      it.handle_x = 16'($signed($urandom_range(8191)) - 4096);
      it.handle_y = 16'($signed($urandom_range(8191)) - 4096);
    end
    it.has_nodes = ($urandom_range(9) != 0);
    return it;
  endfunction

  task automatic set_random_regs(input int phase_no);
    write_reg(CFG_MODE, 16'({2'($urandom_range(3)), 1'($urandom_range(1)),
                             3'($urandom_range(7))}));
    write_reg(CFG_SPEED, (phase_no % 3 == 0) ? 16'hFFFF : 16'($urandom));
    write_reg(CFG_HEIGHT, 16'($urandom));
    write_reg(CFG_ASP_X, (phase_no % 4 == 1) ? 16'h8000 : 16'($urandom));
    write_reg(CFG_ASP_Y, (phase_no % 4 == 2) ? 16'h7FFF : 16'($urandom));
    write_reg(CFG_PHASE, 16'($urandom));
    write_reg(CFG_FREQ_X, 16'($urandom_range(65535)));
    write_reg(CFG_FREQ_Y, 16'($urandom_range(2047)));
  endtask

  initial begin
    in_t it;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: every shape and output mode, field extremes, no nodes, no handle
    for (int sh = 0; sh < 8; sh++) begin
      write_reg(CFG_MODE, 16'({2'(sh % 4), 1'(sh[0]), 3'(sh)}));
      write_reg(CFG_FREQ_X, (sh == 5) ? 16'h0500 : 16'h0300);
      it = '0;
      it.has_nodes = 1'b1;
      it.has_handle = 1'b1;
      it.handle_x = 16'sh7FFF; it.handle_y = 16'sh8000;
      it.tick_position = 17'd65536;
      pending_items.push_back(it);
      it.centre_x = 16'sh8000; it.centre_y = 16'sh7FFF;
      it.tick_position = 17'd16384;
      it.last_source = 1'b1;
      pending_items.push_back(it);
      it.has_handle = 1'b0;
      pending_items.push_back(it);
      drain_all();
    end
    it = '1;
    it.has_nodes = 1'b0;
    pending_items.push_back(it);
    drain_all();

    // Random phases
    for (int ph = 0; ph < 12; ph++) begin
      case (ph % 4)
        0: send_idle_pct = 0;
        1: send_idle_pct = 48;
        2: send_idle_pct = 0;
        default: send_idle_pct = 9;
      endcase
      set_random_regs(ph);
      for (int i = 0; i < 95; i++) begin
        pending_items.push_back(rand_item());
        if (i == 50 && ph == 5) begin
          // let the queued items go, then hold the sender until all results are back
          while (pending_items.size() > 0) @(posedge clk_i);
          hold_off = 1'b1;
          while (expected_points.size() > 0) @(posedge clk_i);
          repeat (5) @(posedge clk_i);
          hold_off = 1'b0;
        end
      end
      drain_all();
    end

    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
